[rtl/psgb_pkg.sv]
// shared types, constants and helpers for the point source grid binner
// no dependencies; the rtl files but psgb_ram use scoped names, verif files import it
package psgb_pkg;

   // grid storage
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int NBINS    = MAX_COLS * MAX_ROWS;
   localparam int BIN_W    = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // field widths
   localparam int POS_W     = 32;
   localparam int HALF_W    = 31;
   localparam int SCALE_W   = 32;
   localparam int PIX_W     = 7;
   localparam int OUT_COL_W = 6;
   localparam int OUT_ROW_W = 6;
   localparam int SUM_W     = 48;
   localparam int HIT_W     = 24;
   localparam int WORD_W    = SUM_W + HIT_W;

   // saturation limits
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [HIT_W-1:0]        HIT_MAX = {HIT_W{1'b1}};

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_HALF   = 3'd0,
      REG_Y_HALF   = 3'd1,
      REG_X_SCALE  = 3'd2,
      REG_Y_SCALE  = 3'd3,
      REG_X_PIXELS = 3'd4,
      REG_Y_PIXELS = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic [HALF_W-1:0]  X_HALF_RESET   = '0;
   localparam logic [HALF_W-1:0]  Y_HALF_RESET   = '0;
   localparam logic [SCALE_W-1:0] X_SCALE_RESET  = 32'd65536;
   localparam logic [SCALE_W-1:0] Y_SCALE_RESET  = 32'd65536;
   localparam logic [PIX_W-1:0]   X_PIXELS_RESET = 7'd64;
   localparam logic [PIX_W-1:0]   Y_PIXELS_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]              opcode;
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
      logic signed [POS_W-1:0] flux;
      logic [OUT_COL_W-1:0]    read_col;
      logic [OUT_ROW_W-1:0]    read_row;
   } req_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0]    bin_col;
      logic [OUT_ROW_W-1:0]    bin_row;
      logic                    in_range;
      logic signed [SUM_W-1:0] flux_sum;
      logic [HIT_W-1:0]        hit_count;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0]  x_half_width;
      logic [HALF_W-1:0]  y_half_width;
      logic [SCALE_W-1:0] x_scale;
      logic [SCALE_W-1:0] y_scale;
      logic [PIX_W-1:0]   x_pixels;
      logic [PIX_W-1:0]   y_pixels;
   } cfg_type;

   // one classified request, handed from front to back
   typedef struct packed {
      opcode_type              op;
      logic                    hit;
      logic [OUT_COL_W-1:0]    col;
      logic [OUT_ROW_W-1:0]    row;
      logic [BIN_W-1:0]        bin;
      logic signed [POS_W-1:0] flux;
   } entry_type;

   // pixel count clamped to the storage limit
   function automatic logic [31:0] clamp_pix(logic [PIX_W-1:0] pix, int limit);
      logic [31:0] wide;
      wide = 32'(pix);
      return (wide > 32'(limit)) ? 32'(limit) : wide;
   endfunction

endpackage

[rtl/psgb_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module psgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/psgb_csr.sv]
// configuration registers behind the apb-style register port
// depends on psgb_pkg
module psgb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [psgb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [psgb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [psgb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output psgb_pkg::cfg_type                cfg
);

   psgb_pkg::cfg_type       cfg_ff, cfg_in;
   psgb_pkg::csr_index_type idx;
   logic                    wr;

   assign idx        = psgb_pkg::csr_index_type'(csr_paddr[psgb_pkg::CSR_ADDR_W-1:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            psgb_pkg::REG_X_HALF: begin
               cfg_in.x_half_width = csr_pwdata[psgb_pkg::HALF_W-1:0];
            end
            psgb_pkg::REG_Y_HALF: begin
               cfg_in.y_half_width = csr_pwdata[psgb_pkg::HALF_W-1:0];
            end
            psgb_pkg::REG_X_SCALE: begin
               cfg_in.x_scale = csr_pwdata[psgb_pkg::SCALE_W-1:0];
            end
            psgb_pkg::REG_Y_SCALE: begin
               cfg_in.y_scale = csr_pwdata[psgb_pkg::SCALE_W-1:0];
            end
            psgb_pkg::REG_X_PIXELS: begin
               cfg_in.x_pixels = csr_pwdata[psgb_pkg::PIX_W-1:0];
            end
            psgb_pkg::REG_Y_PIXELS: begin
               cfg_in.y_pixels = csr_pwdata[psgb_pkg::PIX_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_half_width <= psgb_pkg::X_HALF_RESET;
         cfg_ff.y_half_width <= psgb_pkg::Y_HALF_RESET;
         cfg_ff.x_scale      <= psgb_pkg::X_SCALE_RESET;
         cfg_ff.y_scale      <= psgb_pkg::Y_SCALE_RESET;
         cfg_ff.x_pixels     <= psgb_pkg::X_PIXELS_RESET;
         cfg_ff.y_pixels     <= psgb_pkg::Y_PIXELS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         psgb_pkg::REG_X_HALF:   csr_prdata = 32'(cfg_ff.x_half_width);
         psgb_pkg::REG_Y_HALF:   csr_prdata = 32'(cfg_ff.y_half_width);
         psgb_pkg::REG_X_SCALE:  csr_prdata = cfg_ff.x_scale;
         psgb_pkg::REG_Y_SCALE:  csr_prdata = cfg_ff.y_scale;
         psgb_pkg::REG_X_PIXELS: csr_prdata = 32'(cfg_ff.x_pixels);
         psgb_pkg::REG_Y_PIXELS: csr_prdata = 32'(cfg_ff.y_pixels);
         default:                csr_prdata = '0;
      endcase
   end

endmodule

[rtl/psgb_queue.sv]
// short flip-flop queue of classified requests between front and back
// depends on psgb_pkg
module psgb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psgb_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output psgb_pkg::entry_type head,
   output logic                empty
);

   psgb_pkg::entry_type               slot_ff [psgb_pkg::Q_DEPTH];
   logic [psgb_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [psgb_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [psgb_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                              do_push, do_pop;

   assign full    = (count_ff == psgb_pkg::Q_CNT_W'(psgb_pkg::Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == psgb_pkg::Q_PTR_W'(psgb_pkg::Q_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == psgb_pkg::Q_PTR_W'(psgb_pkg::Q_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/psgb_front.sv]
// front end: accepts requests, locates the bin of a source and classifies each request
// depends on psgb_pkg; feeds psgb_queue
module psgb_front (
   input  logic                clock,
   input  logic                reset,
   input  psgb_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  psgb_pkg::req_type   req_data,
   input  logic                sweep_busy,
   output logic                push,
   output psgb_pkg::entry_type push_data,
   input  logic                q_full
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MULX = 4'b0010,
      F_MULY = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type                  state_ff, state_in;
   logic [1:0]                       op_ff, op_in;
   logic [psgb_pkg::POS_W:0]         sx_ff, sx_in;
   logic [psgb_pkg::POS_W:0]         sy_ff, sy_in;
   logic signed [psgb_pkg::POS_W-1:0] flux_ff, flux_in;
   logic [psgb_pkg::OUT_COL_W-1:0]   rcol_ff, rcol_in;
   logic [psgb_pkg::OUT_ROW_W-1:0]   rrow_ff, rrow_in;
   logic [63:0]                      prod_ff, prod_in;
   logic [psgb_pkg::COL_W-1:0]       col_ff, col_in;
   logic                             okx_ff, okx_in;
   logic [31:0]                      npx, npy;
   logic                             oky;
   logic [psgb_pkg::ROW_W-1:0]       row_idx;
   logic                             read_hit;

   assign npx       = psgb_pkg::clamp_pix(cfg.x_pixels, psgb_pkg::MAX_COLS);
   assign npy       = psgb_pkg::clamp_pix(cfg.y_pixels, psgb_pkg::MAX_ROWS);
   assign req_stall = (state_ff != F_IDLE) || sweep_busy;

   // sequencer: one shared multiplier, x product then y product
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      flux_in  = flux_ff;
      rcol_in  = rcol_ff;
      rrow_in  = rrow_ff;
      prod_in  = prod_ff;
      col_in   = col_ff;
      okx_in   = okx_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !sweep_busy) begin
               op_in   = req_data.opcode;
               sx_in   = {req_data.x_pos[psgb_pkg::POS_W-1], req_data.x_pos}
                         + {2'b00, cfg.x_half_width};
               sy_in   = {req_data.y_pos[psgb_pkg::POS_W-1], req_data.y_pos}
                         + {2'b00, cfg.y_half_width};
               flux_in = req_data.flux;
               rcol_in = req_data.read_col;
               rrow_in = req_data.read_row;
               state_in = (psgb_pkg::opcode_type'(req_data.opcode) == psgb_pkg::OP_ADD)
                          ? F_MULX : F_PUSH;
            end
         end
         F_MULX: begin
            prod_in  = sx_ff[psgb_pkg::POS_W-1:0] * cfg.x_scale;
            state_in = F_MULY;
         end
         F_MULY: begin
            okx_in   = !sx_ff[psgb_pkg::POS_W] && (prod_ff[63:32] < npx);
            col_in   = prod_ff[32 +: psgb_pkg::COL_W];
            prod_in  = sy_ff[psgb_pkg::POS_W-1:0] * cfg.y_scale;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push = 1'b1;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // classification of the held request
   assign oky      = !sy_ff[psgb_pkg::POS_W] && (prod_ff[63:32] < npy);
   assign row_idx  = prod_ff[32 +: psgb_pkg::ROW_W];
   assign read_hit = (32'(rcol_ff) < 32'(psgb_pkg::MAX_COLS))
                     && (32'(rrow_ff) < 32'(psgb_pkg::MAX_ROWS));

   always_comb begin
      push_data.op   = psgb_pkg::opcode_type'(op_ff);
      push_data.hit  = 1'b0;
      push_data.col  = '0;
      push_data.row  = '0;
      push_data.bin  = '0;
      push_data.flux = flux_ff;
      case (psgb_pkg::opcode_type'(op_ff))
         psgb_pkg::OP_ADD: begin
            if (okx_ff && oky) begin
               push_data.hit = 1'b1;
               push_data.col = psgb_pkg::OUT_COL_W'(col_ff);
               push_data.row = psgb_pkg::OUT_ROW_W'(row_idx);
               push_data.bin = psgb_pkg::BIN_W'(32'(row_idx) * 32'(psgb_pkg::MAX_COLS)
                                                + 32'(col_ff));
            end
         end
         psgb_pkg::OP_READ: begin
            push_data.hit = read_hit;
            push_data.col = rcol_ff;
            push_data.row = rrow_ff;
            push_data.bin = psgb_pkg::BIN_W'(32'(rrow_ff) * 32'(psgb_pkg::MAX_COLS)
                                             + 32'(rcol_ff));
         end
         default: begin
            push_data.hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload holding registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      flux_ff <= flux_in;
      rcol_ff <= rcol_in;
      rrow_ff <= rrow_in;
      prod_ff <= prod_in;
      col_ff  <= col_in;
      okx_ff  <= okx_in;
   end

endmodule

[rtl/psgb_back.sv]
// back end: bin ram read-modify-write, bin reads, clearing sweep and the result register
// depends on psgb_pkg and psgb_ram; drains psgb_queue
module psgb_back (
   input  logic                clock,
   input  logic                reset,
   input  psgb_pkg::entry_type head,
   input  logic                q_empty,
   output logic                pop,
   output logic                sweep_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psgb_pkg::rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      B_SWEEP  = 3'b001,
      B_IDLE   = 3'b010,
      B_UPDATE = 3'b100
   } back_state_type;

   back_state_type                    state_ff, state_in;
   logic [psgb_pkg::BIN_W-1:0]        sweep_ff, sweep_in;
   psgb_pkg::entry_type               cur_ff, cur_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   psgb_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              wr_en;
   logic [psgb_pkg::BIN_W-1:0]        wr_addr;
   logic [psgb_pkg::WORD_W-1:0]       wr_data;
   logic [psgb_pkg::WORD_W-1:0]       rd_data;

   logic                              out_free;
   logic signed [psgb_pkg::SUM_W-1:0] old_sum;
   logic [psgb_pkg::HIT_W-1:0]        old_hits;
   logic signed [psgb_pkg::SUM_W:0]   sum_wide;
   logic signed [psgb_pkg::SUM_W-1:0] new_sum;
   logic [psgb_pkg::HIT_W-1:0]        new_hits;

   psgb_ram #(
      .WIDTH (psgb_pkg::WORD_W),
      .DEPTH (psgb_pkg::NBINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head.bin),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_busy = (state_ff == B_SWEEP);
   assign pop        = (state_ff == B_IDLE) && !q_empty;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // saturating accumulate of the stored bin
   assign old_sum  = rd_data[psgb_pkg::WORD_W-1 -: psgb_pkg::SUM_W];
   assign old_hits = rd_data[psgb_pkg::HIT_W-1:0];
   assign sum_wide = {old_sum[psgb_pkg::SUM_W-1], old_sum}
                     + {{(psgb_pkg::SUM_W + 1 - psgb_pkg::POS_W){cur_ff.flux[psgb_pkg::POS_W-1]}},
                        cur_ff.flux};

   always_comb begin
      if (sum_wide[psgb_pkg::SUM_W] != sum_wide[psgb_pkg::SUM_W-1]) begin
         new_sum = sum_wide[psgb_pkg::SUM_W] ? psgb_pkg::SUM_MIN : psgb_pkg::SUM_MAX;
      end else begin
         new_sum = sum_wide[psgb_pkg::SUM_W-1:0];
      end
      new_hits = (old_hits == psgb_pkg::HIT_MAX) ? old_hits : old_hits + 1'b1;
   end

   // sequencer and result register load
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff.bin;
      wr_data      = {new_sum, new_hits};
      case (state_ff)
         B_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
            if (sweep_ff == psgb_pkg::BIN_W'(psgb_pkg::NBINS - 1)) begin
               state_in = B_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               cur_in   = head;
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.bin_col   = cur_ff.col;
               rsp_data_in.bin_row   = cur_ff.row;
               rsp_data_in.in_range  = cur_ff.hit;
               rsp_data_in.flux_sum  = '0;
               rsp_data_in.hit_count = '0;
               state_in              = B_IDLE;
               if (cur_ff.hit && (cur_ff.op == psgb_pkg::OP_ADD)) begin
                  wr_en                 = 1'b1;
                  rsp_data_in.flux_sum  = new_sum;
                  rsp_data_in.hit_count = new_hits;
               end else if (cur_ff.hit && (cur_ff.op == psgb_pkg::OP_READ)) begin
                  rsp_data_in.flux_sum  = old_sum;
                  rsp_data_in.hit_count = old_hits;
               end
               if (cur_ff.op == psgb_pkg::OP_CLEAR) begin
                  sweep_in = '0;
                  state_in = B_SWEEP;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/point_source_grid_binner_top.sv]
// top level of the point source grid binner: register port, front end, queue, back end
// depends on psgb_pkg, psgb_csr, psgb_front, psgb_queue, psgb_back
//
// Bins point sources onto a 64 x 64 grid of saturating flux sums and hit counts and answers
// every request (add source, read bin, clear all bins, unused code) with exactly one result
// beat. An add passes the front end's idle, column multiply, row multiply and push states,
// using its single shared 32 x 32 multiplier for the column product, then the row product;
// other requests go from idle straight to push. The back end does the read-modify-write of
// the bin ram through its one registered read port. Each half ends one request before it
// takes the next, with a 2-entry queue letting the two halves stall apart. After reset and
// after every clear the back end sweeps all 4096 bins to zero, one per cycle, during which
// no request is taken (a clear's own result beat is issued before its sweep).
// Registers sit at byte addresses 4*i and should be written only while the block is idle.
module point_source_grid_binner_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  psgb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output psgb_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [psgb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [psgb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [psgb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   psgb_pkg::cfg_type   cfg;
   psgb_pkg::entry_type push_data;
   psgb_pkg::entry_type head;
   logic                push, q_full, pop, q_empty, sweep_busy;

   psgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   psgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .sweep_busy (sweep_busy),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   psgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty)
   );

   psgb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .sweep_busy (sweep_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[verif/psgb_bin_checker.sv]
`timescale 1ns / 100ps
// result checker for the point source grid binner: shadows the grid registers and bin store,
// predicts every result beat from the request beats and compares it field by field
// depends on psgb_pkg
module psgb_bin_checker
   import psgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    failures,
   output int                    outstanding
);

   // shadow of the grid registers and of the bin store
   cfg_type                 grid;
   logic signed [SUM_W-1:0] sum_store  [NBINS];
   logic [HIT_W-1:0]        hits_store [NBINS];
   bit                      live_store [NBINS];
   rsp_type                 bins_due [$];
   rsp_type                 due;
   int                      miss_count = 0;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   // cell index of one coordinate, 0 when the source falls off the grid
   function automatic bit locate_cell(input logic signed [POS_W-1:0] pos,
         input logic [HALF_W-1:0] half, input logic [SCALE_W-1:0] scale,
         input logic [PIX_W-1:0] npix, input int limit, output logic [5:0] pix_idx);
      longint      shifted;
      logic [63:0] product;
      logic [63:0] span;
      span    = (npix > limit) ? 64'(limit) : 64'(npix);
      shifted = longint'(pos) + longint'(half);
      pix_idx = '0;
      if (shifted < 0)
         return 1'b0;
      product = 64'(shifted) * 64'(scale);
      product = product >> 32;
      if (product >= span)
         return 1'b0;
      pix_idx = 6'(product);
      return 1'b1;
   endfunction

   // applies one request to the shadow store and returns the bin it reports
   function automatic rsp_type bin_outcome(input req_type r);
      rsp_type                 res;
      logic [5:0]              col;
      logic [5:0]              row;
      int                      idx;
      longint                  total;
      logic signed [SUM_W-1:0] cur;
      logic [HIT_W-1:0]        cnt;
      res = '0;
      case (opcode_type'(r.opcode))
         OP_ADD: begin
            if (locate_cell(r.x_pos, grid.x_half_width, grid.x_scale, grid.x_pixels,
                            MAX_COLS, col) &&
                locate_cell(r.y_pos, grid.y_half_width, grid.y_scale, grid.y_pixels,
                            MAX_ROWS, row)) begin
               idx   = int'(row) * MAX_COLS + int'(col);
               cur   = live_store[idx] ? sum_store[idx] : '0;
               cnt   = live_store[idx] ? hits_store[idx] : '0;
               total = longint'(cur) + longint'(r.flux);
               // saturate the sum, stop the count at its top
               if (total > longint'(SUM_MAX))
                  total = longint'(SUM_MAX);
               if (total < longint'(SUM_MIN))
                  total = longint'(SUM_MIN);
               if (cnt != HIT_MAX)
                  cnt++;
               sum_store[idx]  = SUM_W'(total);
               hits_store[idx] = cnt;
               live_store[idx] = 1'b1;
               res.bin_col     = col;
               res.bin_row     = row;
               res.in_range    = 1'b1;
               res.flux_sum    = SUM_W'(total);
               res.hit_count   = cnt;
            end
         end
         OP_READ: begin
            res.bin_col = r.read_col;
            res.bin_row = r.read_row;
            if (int'(r.read_col) < MAX_COLS && int'(r.read_row) < MAX_ROWS) begin
               idx          = int'(r.read_row) * MAX_COLS + int'(r.read_col);
               res.in_range = 1'b1;
               if (live_store[idx]) begin
                  res.flux_sum  = sum_store[idx];
                  res.hit_count = hits_store[idx];
               end
            end
         end
         OP_CLEAR: begin
            foreach (live_store[i])
               live_store[i] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         miss_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         grid = '{x_half_width: X_HALF_RESET, y_half_width: Y_HALF_RESET,
                  x_scale: X_SCALE_RESET, y_scale: Y_SCALE_RESET,
                  x_pixels: X_PIXELS_RESET, y_pixels: Y_PIXELS_RESET};
         foreach (live_store[i])
            live_store[i] = 1'b0;
         bins_due.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (bins_due.size() == 0) begin
               $display("%0t: result beat with none expected, got %p", $time, rsp_data);
               miss_count++;
            end else begin
               due = bins_due.pop_front();
               check_field("bin_col", 64'(due.bin_col), 64'(rsp_data.bin_col));
               check_field("bin_row", 64'(due.bin_row), 64'(rsp_data.bin_row));
               check_field("in_range", 64'(due.in_range), 64'(rsp_data.in_range));
               check_field("flux_sum", 64'(due.flux_sum), 64'(rsp_data.flux_sum));
               check_field("hit_count", 64'(due.hit_count), 64'(rsp_data.hit_count));
            end
         end
         // register write in its access cycle
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_IDX_W+1:2]))
               REG_X_HALF:   grid.x_half_width = csr_pwdata[HALF_W-1:0];
               REG_Y_HALF:   grid.y_half_width = csr_pwdata[HALF_W-1:0];
               REG_X_SCALE:  grid.x_scale      = csr_pwdata[SCALE_W-1:0];
               REG_Y_SCALE:  grid.y_scale      = csr_pwdata[SCALE_W-1:0];
               REG_X_PIXELS: grid.x_pixels     = csr_pwdata[PIX_W-1:0];
               REG_Y_PIXELS: grid.y_pixels     = csr_pwdata[PIX_W-1:0];
               default: ;
            endcase
         end
         // request beat: predict its result
         if (req_valid && !req_stall)
            bins_due.push_back(bin_outcome(req_data));
      end
      failures    <= miss_count;
      outstanding <= bins_due.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// testbench top for the point source grid binner: clock, reset, register setup, request
// stimulus with bursts and gaps, result stalls and the verdict
// depends on psgb_pkg, point_source_grid_binner_top and psgb_bin_checker
module tb_top;
   import psgb_pkg::*;

   localparam logic [31:0] ONE = 32'h0001_0000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    outstanding;

   cfg_type grid;
   int      burst_left = 0;
   int      stall_pct  = 0;
   int      stall_span = 0;

   point_source_grid_binner_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   psgb_bin_checker bin_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // result stalls: a new stall density after each span of random length, none at times
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 60;
            default: stall_pct <= 90;
         endcase
      end else begin
         stall_span <= stall_span - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // one request beat; valid stays up inside a burst, drops for a gap after it
   task automatic send_req(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // hold requests until every predicted result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type g);
      settle();
      grid = g;
      csr_write(REG_X_HALF, 32'(g.x_half_width));
      csr_write(REG_Y_HALF, 32'(g.y_half_width));
      csr_write(REG_X_SCALE, g.x_scale);
      csr_write(REG_Y_SCALE, g.y_scale);
      csr_write(REG_X_PIXELS, 32'(g.x_pixels));
      csr_write(REG_Y_PIXELS, 32'(g.y_pixels));
   endtask

   // coordinate that mostly lands on the grid, sometimes just off either side
   function automatic logic [31:0] grid_coord(input logic [HALF_W-1:0] half,
         input logic [SCALE_W-1:0] scale, input logic [PIX_W-1:0] npix, input int limit);
      logic [63:0] reach;
      logic [63:0] cap;
      logic [63:0] u;
      int unsigned cells;
      cells = (npix > limit) ? limit : npix;
      if (cells == 0)
         return $urandom;
      cap   = 64'(half) + 64'h7FFF_FFFF;
      reach = (scale == '0) ? cap : ((64'(cells) << 32) - 64'd1) / 64'(scale);
      if (reach > cap)
         reach = cap;
      case ($urandom_range(0, 19))
         0: u = '0;
         1: u = reach;
         2: u = (reach < cap) ? reach + 64'd1 : reach;
         3: return 32'(~64'(half));   // one step left of the grid
         default: u = 64'($urandom_range(0, 32'(reach)));
      endcase
      return 32'(u - 64'(half));
   endfunction

   function automatic req_type random_req();
      req_type     r;
      int          pick;
      int unsigned cols;
      int unsigned rows;
      r.opcode   = OP_ADD;
      r.x_pos    = $urandom;
      r.y_pos    = $urandom;
      r.flux     = $urandom;
      r.read_col = OUT_COL_W'($urandom);
      r.read_row = OUT_ROW_W'($urandom);
      cols = (grid.x_pixels > MAX_COLS) ? MAX_COLS : grid.x_pixels;
      rows = (grid.y_pixels > MAX_ROWS) ? MAX_ROWS : grid.y_pixels;
      if ($urandom_range(0, 7) == 0)
         r.flux = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      pick = $urandom_range(0, 199);
      if (pick < 3) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 7) begin
         r.opcode = OP_NONE;
      end else if (pick < 47) begin
         // reads mostly aim at the cells in use
         r.opcode = OP_READ;
         if (cols != 0 && rows != 0 && pick < 37) begin
            r.read_col = OUT_COL_W'($urandom_range(0, cols - 1));
            r.read_row = OUT_ROW_W'($urandom_range(0, rows - 1));
         end
      end else if (pick >= 62) begin
         r.x_pos = grid_coord(grid.x_half_width, grid.x_scale, grid.x_pixels, MAX_COLS);
         r.y_pos = grid_coord(grid.y_half_width, grid.y_scale, grid.y_pixels, MAX_ROWS);
      end
      return r;
   endfunction

   function automatic req_type make_req(input opcode_type op, input logic [31:0] x,
         input logic [31:0] y, input logic [31:0] f, input logic [5:0] c, input logic [5:0] w);
      req_type r;
      r.opcode   = op;
      r.x_pos    = x;
      r.y_pos    = y;
      r.flux     = f;
      r.read_col = c;
      r.read_row = w;
      return r;
   endfunction

   task automatic run_phase(input cfg_type g, input int count);
      configure(g);
      repeat (count) send_req(random_req());
   endtask

   initial begin
      cfg_type mixed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // centered 64 x 64 grid, one unit per cell
      configure('{x_half_width: 31'h0020_0000, y_half_width: 31'h0020_0000,
                  x_scale: ONE, y_scale: ONE, x_pixels: 7'd64, y_pixels: 7'd64});

      // same bin hit with both flux extremes, then read back
      send_req(make_req(OP_ADD, 32'h0, 32'h0, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h0, 32'h0, 32'h8000_0000, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h0000_8000, 32'h0000_FFFF, 32'h7FFF_FFFF, 6'd0, 6'd0));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd32, 6'd32));
      // grid edges: first and last cell, one step outside on each side
      send_req(make_req(OP_ADD, 32'hFFE0_0000, 32'hFFE0_0000, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'hFFDF_FFFF, 32'h0, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h001F_FFFF, 32'h001F_FFFF, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h0020_0000, 32'h0, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h0, 32'h0020_0000, ONE, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h0, 32'hFFDF_FFFF, ONE, 6'd0, 6'd0));
      // position extremes
      send_req(make_req(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0));
      send_req(make_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0, 6'd0));
      // reads of touched and untouched bins
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd63, 6'd63));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd5, 6'd9));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd63, 6'd0));
      // unused code, then clear and check the bins start over
      send_req(make_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
      send_req(make_req(OP_CLEAR, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd32, 6'd32));
      send_req(make_req(OP_ADD, 32'h0, 32'h0, 32'hFFFF_0000, 6'd0, 6'd0));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
      send_req(make_req(OP_READ, 32'h0, 32'h0, 32'h0, 6'd32, 6'd32));
      send_req(make_req(OP_NONE, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));

      // small 4 x 4 grid, many sources per bin
      run_phase('{x_half_width: 31'h0002_0000, y_half_width: 31'h0002_0000,
                  x_scale: ONE, y_scale: ONE, x_pixels: 7'd4, y_pixels: 7'd4}, 150);
      // column count above storage, fine pixels
      run_phase('{x_half_width: 31'h0000_8000, y_half_width: 31'h0,
                  x_scale: 32'h0004_0000, y_scale: 32'h0004_0000,
                  x_pixels: 7'd127, y_pixels: 7'd3}, 130);
      // widest half width, zero and full scale
      run_phase('{x_half_width: 31'h7FFF_FFFF, y_half_width: 31'h0,
                  x_scale: 32'h0, y_scale: 32'hFFFF_FFFF,
                  x_pixels: 7'd64, y_pixels: 7'd64}, 130);
      // no columns at all: every source dropped
      run_phase('{x_half_width: 31'h0010_0000, y_half_width: 31'h0010_0000,
                  x_scale: ONE, y_scale: ONE, x_pixels: 7'd0, y_pixels: 7'd1}, 40);
      // random geometry
      mixed.x_half_width = HALF_W'($urandom_range(0, 32'h0040_0000));
      mixed.y_half_width = HALF_W'($urandom_range(0, 32'h0040_0000));
      mixed.x_scale      = $urandom_range(32'h0000_1000, 32'h0010_0000);
      mixed.y_scale      = $urandom_range(32'h0000_1000, 32'h0010_0000);
      mixed.x_pixels     = PIX_W'($urandom_range(1, 64));
      mixed.y_pixels     = PIX_W'($urandom_range(1, 64));
      run_phase(mixed, 150);
      // power-on geometry
      run_phase('{x_half_width: X_HALF_RESET, y_half_width: Y_HALF_RESET,
                  x_scale: X_SCALE_RESET, y_scale: Y_SCALE_RESET,
                  x_pixels: X_PIXELS_RESET, y_pixels: Y_PIXELS_RESET}, 130);
      // single bin takes every source that lands
      run_phase('{x_half_width: 31'h0, y_half_width: 31'h0,
                  x_scale: ONE, y_scale: ONE, x_pixels: 7'd1, y_pixels: 7'd1}, 150);

      settle();
      if (failures == 0)
         $display("point_source_grid_binner_top test passed");
      else
         $display("point_source_grid_binner_top test failed");
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("point_source_grid_binner_top test failed");
      $finish;
   end

endmodule
